### rtl/core/u128d_pkg.sv
// Shared constants and digit arithmetic for the 128-bit binary to decimal converter.
package u128d_pkg;

   localparam int VALUE_W            = 64;
   localparam int BIT_COUNT          = 2 * VALUE_W;
   localparam int BIT_CNT_W          = $clog2(BIT_COUNT);
   localparam int DIGIT_W            = 4;
   localparam int COUNT_W            = 6;
   localparam int MAX_DIGITS_DEFAULT = 39;
   localparam logic [DIGIT_W-1:0] DIGIT_CARRY_MIN = DIGIT_W'(5);
   localparam logic [DIGIT_W:0]   DIGIT_BASE      = (DIGIT_W+1)'(10);

   // A digit of five or more carries out when doubled
   function automatic logic digit_carry(input logic [DIGIT_W-1:0] d);
      return d >= DIGIT_CARRY_MIN;
   endfunction

   // Double a decimal digit, add the incoming carry, keep the low decimal place
   function automatic logic [DIGIT_W-1:0] digit_double(input logic [DIGIT_W-1:0] d,
                                                        input logic cin);
      logic [DIGIT_W:0] sum;
      sum = {d, cin};
      if (digit_carry(d)) begin
         sum = sum - DIGIT_BASE;
      end
      return sum[DIGIT_W-1:0];
   endfunction

endpackage

### rtl/core/u128d_conv.sv
// Bit-serial shift-and-double conversion of one 128-bit number into a BCD digit register.
module u128d_conv #(
   parameter int MAX_DIGITS = u128d_pkg::MAX_DIGITS_DEFAULT,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [u128d_pkg::VALUE_W-1:0]          value_high,
   input  logic [u128d_pkg::VALUE_W-1:0]          value_low,
   output logic                                   done_valid,
   input  logic                                   done_ready,
   output logic [MAX_DIGITS*u128d_pkg::DIGIT_W-1:0] bcd,
   output logic [CNT_W-1:0]                       used
);
   import u128d_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [BIT_COUNT-1:0]          shift_ff, shift_in;
   logic [BIT_CNT_W-1:0]          bit_cnt_ff, bit_cnt_in;
   logic [MAX_DIGITS*DIGIT_W-1:0] bcd_ff, bcd_in, bcd_step;
   logic [MAX_DIGITS-1:0]         top_ff, top_in;
   logic [CNT_W-1:0]              used_ff, used_in;
   logic [MAX_DIGITS-1:0]         carry_vec;
   logic [MAX_DIGITS-1:0]         cin_vec;
   logic                          top_carry;

   // Per-digit doubling; each digit's carry out depends on that digit alone
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_digit
      if (i == 0) begin : g_low
         assign cin_vec[i] = shift_ff[BIT_COUNT-1];
      end else begin : g_up
         assign cin_vec[i] = carry_vec[i-1];
      end
      assign carry_vec[i] = digit_carry(bcd_ff[i*DIGIT_W +: DIGIT_W]);
      assign bcd_step[i*DIGIT_W +: DIGIT_W] =
         digit_double(bcd_ff[i*DIGIT_W +: DIGIT_W], cin_vec[i]);
   end

   // Carry out of the current top digit opens a new digit
   assign top_carry = |(top_ff & carry_vec);

   // Sequence: load, 128 shift steps, hand over
   always_comb begin
      state_in   = state_ff;
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      bcd_in     = bcd_ff;
      top_in     = top_ff;
      used_in    = used_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               shift_in   = {value_high, value_low};
               bit_cnt_in = '0;
               bcd_in     = '0;
               top_in     = MAX_DIGITS'(1);
               used_in    = CNT_W'(1);
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            shift_in   = {shift_ff[BIT_COUNT-2:0], 1'b0};
            bcd_in     = bcd_step;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (top_carry && (used_ff != CNT_W'(MAX_DIGITS))) begin
               top_in  = {top_ff[MAX_DIGITS-2:0], 1'b0};
               used_in = used_ff + CNT_W'(1);
            end
            if (bit_cnt_ff == BIT_CNT_W'(BIT_COUNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the datapath
   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      bit_cnt_ff <= bit_cnt_in;
      bcd_ff     <= bcd_in;
      top_ff     <= top_in;
      used_ff    <= used_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);
   assign bcd        = bcd_ff;
   assign used       = used_ff;

endmodule

### rtl/core/u128d_emit.sv
// Digit output stage: drops leading zero digits and sends the rest most significant first.
module u128d_emit #(
   parameter int MAX_DIGITS = u128d_pkg::MAX_DIGITS_DEFAULT,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1)
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load_valid,
   output logic                                     load_ready,
   input  logic [MAX_DIGITS*u128d_pkg::DIGIT_W-1:0] bcd,
   input  logic [CNT_W-1:0]                         used,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [u128d_pkg::DIGIT_W-1:0]            rsp_digit,
   output logic [u128d_pkg::COUNT_W-1:0]            rsp_digit_count,
   output logic                                     rsp_last
);
   import u128d_pkg::*;

   localparam int WIN_W = MAX_DIGITS * DIGIT_W;

   logic             busy_ff, busy_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             send;
   logic             last;
   logic             step;

   // Top digit of the window is live once the leading zeros are gone
   assign send = busy_ff && (pos_ff <= used_ff);
   assign last = (pos_ff == CNT_W'(1));
   assign step = busy_ff && (!send || rsp_ready);

   // Load a finished conversion, then shift the window up one digit per step
   always_comb begin
      busy_in = busy_ff;
      win_in  = win_ff;
      pos_in  = pos_ff;
      used_in = used_ff;
      if (!busy_ff) begin
         if (load_valid) begin
            busy_in = 1'b1;
            win_in  = bcd;
            pos_in  = CNT_W'(MAX_DIGITS);
            used_in = used;
         end
      end else if (step) begin
         win_in = {win_ff[WIN_W-DIGIT_W-1:0], DIGIT_W'(0)};
         pos_in = pos_ff - CNT_W'(1);
         if (send && last) begin
            busy_in = 1'b0;
         end
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Advance the digit window
   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      pos_ff  <= pos_in;
      used_ff <= used_in;
   end

   assign load_ready      = !busy_ff;
   assign rsp_valid       = send;
   assign rsp_digit       = win_ff[WIN_W-1 -: DIGIT_W];
   assign rsp_digit_count = COUNT_W'(used_ff);
   assign rsp_last        = last;

endmodule

### rtl/core/u128_to_decimal_digits.sv
// Top level: 128-bit unsigned number to decimal digits, most significant digit first.
// Flow: an accept state, a shift step for each of the 128 input bits (one input bit per cycle),
//   then a handover once the digit stage is free; that stage drops leading zeros first.
// Overlap: digits of one number are sent (one per cycle while rsp_ready is high) while the
//   next number converts; a new number is taken only after the last one is handed over.
// Reset: synchronous, active high; clears the control state and drops any work in flight.
module u128_to_decimal_digits #(
   parameter int MAX_DIGITS = u128d_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [u128d_pkg::VALUE_W-1:0] req_value_high,
   input  logic [u128d_pkg::VALUE_W-1:0] req_value_low,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [u128d_pkg::DIGIT_W-1:0] rsp_digit,
   output logic [u128d_pkg::COUNT_W-1:0] rsp_digit_count,
   output logic                          rsp_last
);
   import u128d_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   logic                          done_valid;
   logic                          done_ready;
   logic [MAX_DIGITS*DIGIT_W-1:0] bcd;
   logic [CNT_W-1:0]              used;

   // Convert one number bit by bit
   u128d_conv #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_conv (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .value_high (req_value_high),
      .value_low  (req_value_low),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .bcd        (bcd),
      .used       (used)
   );

   // Send the digits
   u128d_emit #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (done_valid),
      .load_ready      (done_ready),
      .bcd             (bcd),
      .used            (used),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit       (rsp_digit),
      .rsp_digit_count (rsp_digit_count),
      .rsp_last        (rsp_last)
   );

endmodule
